// ----- hw/rtl/brld_pkg.sv -----
// Shared types and constants for the block RMS loudness detector.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package brld_pkg;

    // Widths fixed by the word formats and the state of the block
    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 16;
    localparam int SUM_W     = 40;
    localparam int ELAPSED_W = 32;
    localparam int WINDOW_W  = 16;
    localparam int RATIO_W   = 9;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;

    // Iterative units: one quotient bit or one root bit per cycle
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int SREM_W     = ROOT_W + 1;

    // Block size default
    localparam int MAX_BLOCK = 512;

    // Register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd5000;
    localparam logic [RATIO_W-1:0]  RATIO_RESET  = 9'd192;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOUD_RATIO_Q8 = 8'd1;

    // Input word kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_end;
    } s_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] peak;
        logic               loud;
    } m_word_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture sample magnitude
        logic tick;       // advance millisecond counter
        logic acc;        // square and accumulate
        logic div_step;   // one restoring division step
        logic sqrt_step;  // one root digit
        logic fin;        // peak update, load output word
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic blk_end;    // valid while acc: this sample closes the block
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/block_rms_loudness_detector.sv -----
// Top level of the block RMS loudness detector.
// Instantiates brld_ctrl and brld_dp; types and constants from brld_pkg.
//
// Usage:
//   s_ channel: one word per audio sample (req_type = sample) or per
//   millisecond tick (req_type = tick). A sample with block_end set, or the
//   sample that fills MaxBlock, closes the block.
//   m_ channel: one word per closed block: level = floor(sqrt(sum/count)),
//   peak after the hold update, and the loud flag.
//   cfg_ channel: register writes (index 0 window_ms, 1 loud_ratio_q8);
//   always ready, unknown indexes are dropped. Write only while idle.
// Timing:
//   A tick is taken in the idle state. A sample that does not close a block
//   passes through capture, then square and accumulate. A closing sample
//   then runs the serial divider, which produces one quotient bit per cycle
//   over the 40-bit sum, the serial root (one digit per cycle) and the final
//   state, where m_valid is registered once the output word is loaded.
// Reset and stall:
//   aresetn (synchronous, active low) clears the sum, count, peak, timer
//   and output valid, and loads window_ms = 5000 and ratio = 192.
//   A result word waits in the output register while m_ready is low; new
//   samples and ticks are still taken meanwhile. Only the next closing
//   block holds in its final cycle until the output register is free.
`default_nettype none

module block_rms_loudness_detector #(
    parameter int MaxBlock = brld_pkg::MAX_BLOCK
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input words
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire brld_pkg::s_word_t               s_data,
    // result words
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output brld_pkg::m_word_t                    m_data,
    // register writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [brld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [brld_pkg::CFG_DATA_W-1:0] cfg_data
);

    brld_pkg::dp_cmd_t  cmd;
    brld_pkg::dp_stat_t st;

    // register writes never stall
    assign cfg_ready = 1'b1;

    brld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_data.req_type),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .st       (st),
        .cmd      (cmd)
    );

    brld_dp #(
        .MaxBlock (MaxBlock)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/brld_ctrl.sv -----
// Controller state machine of the block RMS loudness detector.
// Depends on brld_pkg; drives brld_dp through command and status structs.
`default_nettype none

module brld_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               req_type,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire brld_pkg::dp_stat_t st,
    output brld_pkg::dp_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ACC  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SQRT = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [brld_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (req_type == brld_pkg::REQ_TICK) begin
                        cmd.tick = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                step_next = '0;
                state_next = st.blk_end ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == brld_pkg::STEP_W'(brld_pkg::DIV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == brld_pkg::STEP_W'(brld_pkg::SQRT_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.fin) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/brld_dp.sv -----
// Datapath of the block RMS loudness detector: accumulator, serial divider,
// serial square root, peak hold and configuration registers. Uses brld_pkg.
`default_nettype none

module brld_dp #(
    parameter int MaxBlock = brld_pkg::MAX_BLOCK
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire brld_pkg::dp_cmd_t               cmd,
    output brld_pkg::dp_stat_t                   st,
    input  wire brld_pkg::s_word_t               s_data,
    output brld_pkg::m_word_t                    m_data,
    input  wire logic                            cfg_valid,
    input  wire logic [brld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [brld_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MaxBlock + 1);
    localparam int MAG_W = brld_pkg::SAMPLE_W + 1;
    localparam int SUM_W = brld_pkg::SUM_W;
    localparam int LVL_W = brld_pkg::LEVEL_W;
    localparam int ROOT_W = brld_pkg::ROOT_W;
    localparam int SREM_W = brld_pkg::SREM_W;
    localparam int EL_W  = brld_pkg::ELAPSED_W;
    localparam int CMP_W = LVL_W + brld_pkg::RATIO_W;

    logic [brld_pkg::WINDOW_W-1:0] window_reg;
    logic [brld_pkg::RATIO_W-1:0]  ratio_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic                          last_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [LVL_W-1:0]              peak_reg;
    logic [EL_W-1:0]               elapsed_reg;
    logic [SUM_W-1:0]              work_reg;
    logic [CNT_W-1:0]              drem_reg;
    logic [SREM_W-1:0]             srem_reg;
    logic [ROOT_W-1:0]             root_reg;
    brld_pkg::m_word_t             out_reg;

    // sample magnitude
    logic [MAG_W-1:0] smp_ext;
    logic [MAG_W-1:0] mag_next;
    // accumulate
    logic [2*MAG_W-1:0] sq;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic [CNT_W-1:0]   count_inc;
    // divide step
    logic [CNT_W:0]     drem_sh;
    logic               div_ge;
    logic [CNT_W:0]     drem_sub;
    // root step
    logic [SREM_W+1:0]  srem_sh;
    logic [SREM_W+1:0]  trial;
    logic               sqrt_ge;
    logic [SREM_W+1:0]  srem_sub;
    // finish
    logic [LVL_W-1:0]   level;
    logic               win_over;
    logic [LVL_W-1:0]   peak_base;
    logic [LVL_W-1:0]   peak_new;
    logic [CMP_W-1:0]   lvl_scaled;
    logic [CMP_W-1:0]   thr;

    always_comb begin
        smp_ext  = {s_data.sample[brld_pkg::SAMPLE_W-1], s_data.sample};
        mag_next = s_data.sample[brld_pkg::SAMPLE_W-1] ? (MAG_W'(0) - smp_ext) : smp_ext;

        sq        = mag_reg * mag_reg;
        sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(sq);
        sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        count_inc = count_reg + 1'b1;
        // the accepted word has left the input by now; use the captured flag
        st.blk_end = last_reg || (count_inc >= CNT_W'(MaxBlock));

        drem_sh  = {drem_reg, work_reg[SUM_W-1]};
        div_ge   = drem_sh >= {1'b0, count_reg};
        drem_sub = drem_sh - {1'b0, count_reg};

        srem_sh  = {srem_reg, work_reg[SUM_W-1:SUM_W-2]};
        trial    = (SREM_W + 2)'({root_reg, 2'b01});
        sqrt_ge  = srem_sh >= trial;
        srem_sub = srem_sh - trial;

        level      = root_reg[LVL_W-1:0];
        win_over   = elapsed_reg > EL_W'(window_reg);
        peak_base  = win_over ? '0 : peak_reg;
        peak_new   = (level > peak_base) ? level : peak_base;
        lvl_scaled = CMP_W'({level, 8'd0});
        thr        = CMP_W'(ratio_reg * peak_new);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= brld_pkg::WINDOW_RESET;
            ratio_reg  <= brld_pkg::RATIO_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                brld_pkg::REG_WINDOW_MS:     window_reg <= cfg_data;
                brld_pkg::REG_LOUD_RATIO_Q8: ratio_reg  <= cfg_data[brld_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // block state, timer and peak
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            count_reg   <= '0;
            peak_reg    <= '0;
            elapsed_reg <= '0;
        end else begin
            if (cmd.tick && elapsed_reg != {EL_W{1'b1}}) begin
                elapsed_reg <= elapsed_reg + 1'b1;
            end
            if (cmd.acc) begin
                count_reg <= count_inc;
                sum_reg   <= st.blk_end ? '0 : sum_sat;
            end
            if (cmd.fin) begin
                count_reg <= '0;
                peak_reg  <= peak_new;
                if (win_over) begin
                    elapsed_reg <= '0;
                end
            end
        end
    end

    // payload: magnitude, serial units, output word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg  <= mag_next;
            last_reg <= s_data.block_end;
        end
        if (cmd.acc) begin
            work_reg <= sum_sat;
            drem_reg <= '0;
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.div_step) begin
            work_reg <= {work_reg[SUM_W-2:0], div_ge};
            drem_reg <= div_ge ? drem_sub[CNT_W-1:0] : drem_sh[CNT_W-1:0];
        end
        if (cmd.sqrt_step) begin
            work_reg <= {work_reg[SUM_W-3:0], 2'b00};
            srem_reg <= sqrt_ge ? srem_sub[SREM_W-1:0] : srem_sh[SREM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], sqrt_ge};
        end
        if (cmd.fin) begin
            out_reg.level <= level;
            out_reg.peak  <= peak_new;
            out_reg.loud  <= (lvl_scaled > thr) && (peak_new != '0);
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for block_rms_loudness_detector: directed and random words,
// register settings and random back-pressure. Needs brld_pkg and the block's RTL;
// a scoreboard class predicts every level report and compares it field by field.

import brld_pkg::*;

class loudness_scoreboard;
    logic [WINDOW_W-1:0]  window_ms;
    logic [RATIO_W-1:0]   ratio_q8;
    logic [SUM_W-1:0]     sq_sum;
    int unsigned          blk_samples;
    logic [LEVEL_W-1:0]   held_peak;
    logic [ELAPSED_W-1:0] ms_since_clear;
    m_word_t              level_reports[$];
    int unsigned          n_words, n_blocks, n_forced, n_loud, n_clears, n_bad;

    function new();
        window_ms      = WINDOW_RESET;
        ratio_q8       = RATIO_RESET;
        sq_sum         = '0;
        blk_samples    = 0;
        held_peak      = '0;
        ms_since_clear = '0;
        n_words  = 0;
        n_blocks = 0;
        n_forced = 0;
        n_loud   = 0;
        n_clears = 0;
        n_bad    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WINDOW_MS:     window_ms = data[WINDOW_W-1:0];
            REG_LOUD_RATIO_Q8: ratio_q8  = data[RATIO_W-1:0];
            default: ;
        endcase
    endfunction

    // Bit-by-bit root search, highest root bit first
    function longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 20; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // Note one accepted input word; queue a level report if it closes a block
    function void take_word(s_word_t w);
        int              mag;
        longint unsigned sq;
        longint unsigned total;
        longint unsigned cap;
        longint unsigned lvl;
        m_word_t         rep;
        n_words++;
        if (w.req_type == REQ_TICK) begin
            if (ms_since_clear != '1) ms_since_clear++;
            return;
        end
        cap = (64'd1 << SUM_W) - 1;
        mag = int'($signed(w.sample));
        if (mag < 0) mag = -mag;
        sq = longint'(mag) * longint'(mag);
        total = 64'(sq_sum) + sq;
        if (total > cap) total = cap;
        sq_sum = SUM_W'(total);
        blk_samples++;
        if (!w.block_end && blk_samples < MAX_BLOCK) return;
        if (!w.block_end) n_forced++;

        lvl = floor_sqrt(64'(sq_sum) / 64'(blk_samples));
        if (ms_since_clear > window_ms) begin
            held_peak      = '0;
            ms_since_clear = '0;
            n_clears++;
        end
        if (lvl > held_peak) held_peak = LEVEL_W'(lvl);
        rep.level = LEVEL_W'(lvl);
        rep.peak  = held_peak;
        rep.loud  = (lvl * 256 > 64'(ratio_q8) * 64'(held_peak)) && (held_peak != 0);
        if (rep.loud) n_loud++;
        n_blocks++;
        sq_sum      = '0;
        blk_samples = 0;
        level_reports.push_back(rep);
    endfunction

    // Compare one accepted result word with the oldest queued report
    function void match_result(m_word_t got);
        m_word_t want;
        bit      bad;
        if (level_reports.size() == 0) begin
            n_bad++;
            $error("unexpected result word: level %0d peak %0d loud %0d",
                   got.level, got.peak, got.loud);
            return;
        end
        want = level_reports.pop_front();
        bad  = 1'b0;
        if (got.level !== want.level) begin
            $error("level: expected %0d, actual %0d", want.level, got.level);
            bad = 1'b1;
        end
        if (got.peak !== want.peak) begin
            $error("peak: expected %0d, actual %0d", want.peak, got.peak);
            bad = 1'b1;
        end
        if (got.loud !== want.loud) begin
            $error("loud: expected %0d, actual %0d", want.loud, got.loud);
            bad = 1'b1;
        end
        if (bad) n_bad++;
    endfunction
endclass

module testbench;
    // Quiet time before a register write; covers a closing sample in flight
    localparam int SETTLE_CYCLES = 80;
    // Cycles with no handshake on any channel before the run is declared hung
    localparam int QUIET_LIMIT   = 4000;
    // Length of the long receiver hold-off that fills the block
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_WORDS   = 102;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_LOUD_RATIO_Q8 + 1'b1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    s_word_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    m_word_t               m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int amp_shift      = 0;
    bit hold_req       = 1'b0;
    int n_holds        = 0;
    int n_settings     = 0;

    loudness_scoreboard sb = new();

    block_rms_loudness_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Check every result word taken at a rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.match_result(m_data);
    end

    // Receiver: stall at random, or hold off for a long stretch on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                n_holds++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog: end the run when no channel moves a word for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic s_word_t make_word(logic kind, logic [SAMPLE_W-1:0] smp, logic last);
        s_word_t w;
        w.req_type  = kind;
        w.sample    = smp;
        w.block_end = last;
        return w;
    endfunction

    // Offer one word from a falling edge; hold it until taken, return on a falling edge
    task automatic send_word(input s_word_t w);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_word(w);
        @(negedge aclk);
    endtask

    // Raise the write channel with one register word; leave valid high for the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // Write both registers, optionally a stray index too, then drop valid
    task automatic set_config(input logic [CFG_DATA_W-1:0] win,
                              input logic [CFG_DATA_W-1:0] ratio_word, input bit stray);
        write_reg(REG_WINDOW_MS, win);
        write_reg(REG_LOUD_RATIO_Q8, ratio_word);
        if (stray) write_reg(CFG_IDX_W'($urandom_range(255, REG_FIRST_UNUSED)),
                             CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Drop valid, wait until every queued report has arrived, then let the block settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.level_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Random words: mostly samples grouped into blocks, ticks mixed in
    task automatic run_random(input int n, input int tick_pct, input int end_pct);
        s_word_t             w;
        logic [SAMPLE_W-1:0] raw;
        repeat (n) begin
            if ($urandom_range(7) == 0) amp_shift = $urandom_range(15);
            raw = SAMPLE_W'($urandom);
            case ($urandom_range(9))
                0: raw = 16'h8000;
                1: raw = 16'h7fff;
                2: raw = '0;
                3: raw = $signed(raw) >>> 12;
                default: raw = $signed(raw) >>> amp_shift;
            endcase
            w.req_type  = ($urandom_range(99) < tick_pct) ? REQ_TICK : REQ_SAMPLE;
            w.sample    = raw;
            w.block_end = ($urandom_range(99) < end_pct);
            send_word(w);
        end
    endtask

    initial begin : stimulus
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset register values: silence, both full-scale extremes, ignored tick fields
        send_word(make_word(REQ_SAMPLE, 16'h0000, 1'b1));
        send_word(make_word(REQ_SAMPLE, 16'h7fff, 1'b1));
        send_word(make_word(REQ_SAMPLE, 16'h8000, 1'b1));
        send_word(make_word(REQ_TICK,   16'h8000, 1'b1));   // flag on a tick ends nothing
        send_word(make_word(REQ_TICK,   16'h0000, 1'b0));
        send_word(make_word(REQ_SAMPLE, 16'hffff, 1'b0));
        send_word(make_word(REQ_SAMPLE, 16'h0001, 1'b1));
        send_word(make_word(REQ_SAMPLE, 16'd100, 1'b0));
        send_word(make_word(REQ_SAMPLE, -16'sd200, 1'b0));
        send_word(make_word(REQ_SAMPLE, 16'd300, 1'b1));
        send_word(make_word(REQ_SAMPLE, 16'd30000, 1'b1));  // above the loud threshold
        send_word(make_word(REQ_SAMPLE, 16'd16384, 1'b1));  // below it
        send_word(make_word(REQ_TICK,   16'h7fff, 1'b0));
        drain_results();

        // Zero window: any tick before a block end clears the peak; ratio of one
        set_config(16'd0, 16'd256, 1'b0);
        send_word(make_word(REQ_SAMPLE, 16'd1000, 1'b1));
        send_word(make_word(REQ_TICK,   16'h0000, 1'b0));
        send_word(make_word(REQ_SAMPLE, 16'd1000, 1'b1));
        send_word(make_word(REQ_SAMPLE, 16'd2000, 1'b1));
        drain_results();

        // Widest window, ratio zero: loud on any nonzero level
        set_config(16'd65535, 16'd0, 1'b0);
        send_word(make_word(REQ_SAMPLE, 16'd5, 1'b1));
        send_word(make_word(REQ_SAMPLE, 16'd0, 1'b1));
        send_word(make_word(REQ_TICK,   16'hffff, 1'b1));
        send_word(make_word(REQ_SAMPLE, 16'h8000, 1'b0));
        send_word(make_word(REQ_SAMPLE, 16'h7fff, 1'b1));
        drain_results();

        // Random phases: no idling, then sender idle, then receiver stalling
        set_config(16'd1, 16'd256, 1'b0);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random(PHASE_WORDS, 30, 25);
        drain_results();

        set_config(16'd65535, 16'd0, 1'b0);
        src_idle_pct = 52;
        run_random(PHASE_WORDS, 20, 30);
        drain_results();

        set_config(16'd0, 16'd511, 1'b0);
        src_idle_pct   = 0;
        sink_stall_pct = 52;
        run_random(PHASE_WORDS, 30, 25);
        drain_results();

        // Both sides idle; ratio word carries junk above bit 8; stray index write
        set_config(CFG_DATA_W'($urandom_range(40, 2)), CFG_DATA_W'($urandom), 1'b1);
        src_idle_pct   = 25;
        sink_stall_pct = 25;
        run_random(PHASE_WORDS, 30, 20);
        drain_results();

        // Long receiver hold-off with the sender always offering: fill the block
        set_config(16'd10, 16'(RATIO_RESET), 1'b0);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b1;
        run_random(PHASE_WORDS, 10, 40);
        drain_results();

        // Forced block end: a full block of the most negative sample, no flag
        set_config(16'd3, 16'd128, 1'b0);
        src_idle_pct   = 25;
        sink_stall_pct = 25;
        repeat (MAX_BLOCK) send_word(make_word(REQ_SAMPLE, 16'h8000, 1'b0));
        run_random(PHASE_WORDS, 30, 5);
        drain_results();

        set_config(CFG_DATA_W'($urandom_range(65535, 1)),
                   CFG_DATA_W'($urandom_range(511, 0)), 1'b0);
        src_idle_pct   = 0;
        sink_stall_pct = 52;
        run_random(PHASE_WORDS, 25, 25);
        drain_results();

        $display("Covered %0d input words and %0d level reports (%0d forced ends, %0d loud).",
                 sb.n_words, sb.n_blocks, sb.n_forced, sb.n_loud);
        $display("Peak cleared %0d times over %0d register settings, %0d long hold-offs.",
                 sb.n_clears, n_settings, n_holds);
        if (sb.n_bad == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
